FILE: rtl/core/assert_macros.svh
// Assertion helpers for the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/core/etrs_pkg.sv
package etrs_pkg;

    localparam int DATA_W = 32;
    localparam int ANG_W  = 16;
    localparam int G_W    = 12;

    typedef struct packed {
        logic signed [DATA_W-1:0] pos_x;
        logic signed [DATA_W-1:0] pos_y;
        logic signed [DATA_W-1:0] pos_z;
        logic signed [ANG_W-1:0]  angle_x;
        logic signed [ANG_W-1:0]  angle_y;
        logic signed [ANG_W-1:0]  angle_z;
        logic signed [DATA_W-1:0] scale_x;
        logic signed [DATA_W-1:0] scale_y;
        logic signed [DATA_W-1:0] scale_z;
    } t_in;

    typedef struct packed {
        logic signed [DATA_W-1:0] m00;
        logic signed [DATA_W-1:0] m01;
        logic signed [DATA_W-1:0] m02;
        logic signed [DATA_W-1:0] m10;
        logic signed [DATA_W-1:0] m11;
        logic signed [DATA_W-1:0] m12;
        logic signed [DATA_W-1:0] m20;
        logic signed [DATA_W-1:0] m21;
        logic signed [DATA_W-1:0] m22;
        logic signed [DATA_W-1:0] tx;
        logic signed [DATA_W-1:0] ty;
        logic signed [DATA_W-1:0] tz;
    } t_out;

    // Reduced angle: quadrant, octant reflection flag, angle in [0, 45] deg (Q.6)
    typedef struct packed {
        logic [1:0]     quad;
        logic           swap;
        logic [G_W-1:0] g;
    } t_ang;

    typedef struct packed {
        logic signed [DATA_W-1:0] pos_x;
        logic signed [DATA_W-1:0] pos_y;
        logic signed [DATA_W-1:0] pos_z;
        logic signed [DATA_W-1:0] scale_x;
        logic signed [DATA_W-1:0] scale_y;
        logic signed [DATA_W-1:0] scale_z;
    } t_side;

    typedef struct packed {
        t_side side;
        t_ang  ang_x;
        t_ang  ang_y;
        t_ang  ang_z;
    } t_work;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;
    localparam logic [Q_CNT_W-1:0] Q_FULL_CNT = Q_CNT_W'(Q_DEPTH);

    typedef struct packed {
        logic               full;
        logic               empty;
        logic [Q_CNT_W-1:0] count;
    } t_q_stat;

    // Angle units: degrees in Q.6
    localparam logic [16:0] TURN_U   = 17'd23040;
    localparam logic [16:0] QTR_U    = 17'd5760;
    localparam logic [16:0] EIGHTH_U = 17'd2880;
    localparam logic [16:0] OFFSET_U = 17'd46080;

    // x = g*PI_Q30/11520 split as g*X_INT + (g*X_REM + 5760)/11520
    localparam logic [29:0] X_INT   = 30'd292817;
    localparam logic [24:0] X_REM   = 25'd7586;
    localparam logic [24:0] X_HALF  = 25'd5760;
    localparam logic [34:0] DIV45_M = 35'd186414;
    localparam int          DIV45_S = 23;

    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

    // Series steps: rounding half, reciprocal and shift of each divisor
    localparam int NSTEP = 5;
    localparam logic [31:0] SIN_HALF [NSTEP] = '{32'd55, 32'd36, 32'd21, 32'd10, 32'd3};
    localparam logic [32:0] SIN_M [NSTEP] = '{33'd4997780127, 33'd7635497416,
        33'd6544712071, 33'd6871947674, 33'd5726623062};
    localparam int SIN_S [NSTEP] = '{39, 39, 38, 37, 35};
    localparam logic [31:0] COS_HALF [NSTEP] = '{32'd45, 32'd28, 32'd15, 32'd6, 32'd1};
    localparam logic [32:0] COS_M [NSTEP] = '{33'd6108397933, 33'd4908534053,
        33'd4581298450, 33'd5726623062, 33'd4294967296};
    localparam int COS_S [NSTEP] = '{39, 38, 37, 36, 33};

    localparam int SC_LAT    = 2 * NSTEP + 5;
    localparam int BACK_LAT  = SC_LAT + 6;
    localparam int SIDE_LEN  = BACK_LAT - 1;

    function automatic t_ang reduce_angle(logic signed [ANG_W-1:0] a);
        logic [16:0] r;
        logic [16:0] f;
        t_ang        o;
        r = 17'(int'(a) + int'(OFFSET_U));
        if (r >= TURN_U) r = r - TURN_U;
        if (r >= TURN_U) r = r - TURN_U;
        if (r >= TURN_U) r = r - TURN_U;
        priority if (r >= 17'd17280) begin
            o.quad = 2'd3;
            f = r - 17'd17280;
        end else if (r >= 17'd11520) begin
            o.quad = 2'd2;
            f = r - 17'd11520;
        end else if (r >= QTR_U) begin
            o.quad = 2'd1;
            f = r - QTR_U;
        end else begin
            o.quad = 2'd0;
            f = r;
        end
        o.swap = (f > EIGHTH_U);
        o.g = o.swap ? G_W'(QTR_U - f) : G_W'(f);
        return o;
    endfunction

endpackage

FILE: rtl/core/euler_trs_matrix_compose.sv
// Euler TRS matrix composer: each item (position, three angles in degrees
// Q10.6, three scales in Q16.16) yields the top three rows of T*Rz*Ry*Rx*S
// in saturated Q16.16, with the position passed through as the last column.
// The block takes one item per clock unless the queue is full, and returns
// one result per clock while the queue holds items and no stall holds off.
// An item passes through the front register, the four-entry queue and the
// back pipeline, sized by the five-step sine/cosine series (two stages per
// step) and the rotation-times-scale multiply chain. A stall with a result
// waiting freezes that pipeline while the queue absorbs up to four more items.
`include "assert_macros.svh"

module euler_trs_matrix_compose (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  etrs_pkg::t_in  i_data,
    output logic           o_valid,
    input  logic           i_stall,
    output etrs_pkg::t_out o_data
);
    import etrs_pkg::*;

    t_work   w_work;
    t_work   w_head;
    t_q_stat w_qs;
    logic    w_push;
    logic    w_pop;

    // front: capture the item and classify each angle by quadrant and octant
    etrs_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .i_qs    (w_qs),
        .o_push  (w_push),
        .o_work  (w_work)
    );

    // queue: decouple front from the back pipeline
    etrs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_work  (w_work),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_qs    (w_qs)
    );

    // back: sine/cosine, matrix compose, scale and saturate
    etrs_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .i_qs    (w_qs),
        .o_pop   (w_pop),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    `ASSERT_IMP(a_q_bound, 1'b1, w_qs.count <= Q_FULL_CNT)
    `ASSERT_IMP(a_pop_ok, w_pop, !w_qs.empty)
    `ASSERT_IMP(a_stall_full, o_stall, w_qs.full)
    `ASSERT_NEXT(a_cnt_up, w_push && !w_pop, w_qs.count == $past(w_qs.count) + 1'b1)

endmodule

FILE: rtl/core/etrs_front.sv
module etrs_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  etrs_pkg::t_in  i_data,
    input  etrs_pkg::t_q_stat i_qs,
    output logic           o_push,
    output etrs_pkg::t_work o_work
);
    import etrs_pkg::*;

    logic r_valid;
    logic n_valid;
    t_in  r_item;
    logic w_accept;

    assign o_stall  = r_valid && i_qs.full;
    assign o_push   = r_valid && !i_qs.full;
    assign w_accept = i_valid && !o_stall;

    always_comb begin
        n_valid = r_valid;
        if (w_accept) n_valid = 1'b1;
        else if (o_push) n_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_valid <= 1'b0;
        else r_valid <= n_valid;
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) r_item <= i_data;
    end

    // classify each angle into quadrant and octant
    always_comb begin
        o_work.side.pos_x   = r_item.pos_x;
        o_work.side.pos_y   = r_item.pos_y;
        o_work.side.pos_z   = r_item.pos_z;
        o_work.side.scale_x = r_item.scale_x;
        o_work.side.scale_y = r_item.scale_y;
        o_work.side.scale_z = r_item.scale_z;
        o_work.ang_x = reduce_angle(r_item.angle_x);
        o_work.ang_y = reduce_angle(r_item.angle_y);
        o_work.ang_z = reduce_angle(r_item.angle_z);
    end

endmodule

FILE: rtl/core/etrs_queue.sv
module etrs_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  etrs_pkg::t_work   i_work,
    input  logic              i_pop,
    output etrs_pkg::t_work   o_head,
    output etrs_pkg::t_q_stat o_qs
);
    import etrs_pkg::*;

    t_work              r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wp;
    logic [Q_PTR_W-1:0] r_rp;
    logic [Q_CNT_W-1:0] r_cnt;
    logic [Q_PTR_W-1:0] n_wp;
    logic [Q_PTR_W-1:0] n_rp;
    logic [Q_CNT_W-1:0] n_cnt;

    always_comb begin
        n_wp  = i_push ? r_wp + 1'b1 : r_wp;
        n_rp  = i_pop ? r_rp + 1'b1 : r_rp;
        n_cnt = r_cnt;
        if (i_push && !i_pop) n_cnt = r_cnt + 1'b1;
        else if (i_pop && !i_push) n_cnt = r_cnt - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_work;
    end

    assign o_head     = r_mem[r_rp];
    assign o_qs.full  = (r_cnt == Q_FULL_CNT);
    assign o_qs.empty = (r_cnt == '0);
    assign o_qs.count = r_cnt;

endmodule

FILE: rtl/core/etrs_sincos.sv
module etrs_sincos (
    input  logic               i_clk,
    input  logic               i_en,
    input  etrs_pkg::t_ang     i_ang,
    output logic signed [16:0] o_sin,
    output logic signed [16:0] o_cos
);
    import etrs_pkg::*;

    logic [29:0] r1_base;
    logic [16:0] r1_n8;
    logic [1:0]  r1_quad;
    logic        r1_swap;
    logic [29:0] r2_x;
    logic [1:0]  r2_quad;
    logic        r2_swap;

    logic [29:0] r_hx   [2*NSTEP+1];
    logic [29:0] r_hx2  [2*NSTEP+1];
    logic [1:0]  r_hq   [2*NSTEP+1];
    logic        r_hw   [2*NSTEP+1];
    logic [31:0] r_va_s [NSTEP];
    logic [31:0] r_va_c [NSTEP];
    logic [30:0] r_tb_s [NSTEP];
    logic [30:0] r_tb_c [NSTEP];
    logic [30:0] w_ts   [NSTEP+1];
    logic [30:0] w_tc   [NSTEP+1];

    logic [15:0] r_f_s;
    logic [15:0] r_f_c;
    logic [1:0]  r_f_quad;
    logic        r_f_swap;

    logic [24:0] w_n;
    logic [34:0] w_q45;
    logic [59:0] w_xx;
    logic [60:0] w_sp;
    logic [31:0] w_sr;
    logic [31:0] w_cr;
    logic signed [16:0] w_sv;
    logic signed [16:0] w_cv;

    // radians in Q30
    assign w_n   = 25'(i_ang.g) * X_REM + X_HALF;
    assign w_q45 = 35'(r1_n8) * DIV45_M;
    assign w_xx  = 60'(r2_x) * 60'(r2_x) + (60'd1 << 29);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_base  <= 30'(i_ang.g) * X_INT;
            r1_n8    <= w_n[24:8];
            r1_quad  <= i_ang.quad;
            r1_swap  <= i_ang.swap;
            r2_x     <= r1_base + 30'(w_q45[34:DIV45_S]);
            r2_quad  <= r1_quad;
            r2_swap  <= r1_swap;
            r_hx[0]  <= r2_x;
            r_hx2[0] <= w_xx[59:30];
            r_hq[0]  <= r2_quad;
            r_hw[0]  <= r2_swap;
        end
    end

    assign w_ts[0] = ONE_Q30;
    assign w_tc[0] = ONE_Q30;

    genvar gj;
    generate
        for (gj = 0; gj < 2*NSTEP; gj++) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_hx[gj+1]  <= r_hx[gj];
                    r_hx2[gj+1] <= r_hx2[gj];
                    r_hq[gj+1]  <= r_hq[gj];
                    r_hw[gj+1]  <= r_hw[gj];
                end
            end
        end

        // one Horner step: multiply, then divide via the reciprocal and subtract from one
        for (gj = 0; gj < NSTEP; gj++) begin : g_step
            logic [60:0] w_ps;
            logic [60:0] w_pc;
            logic [65:0] w_ms;
            logic [65:0] w_mc;
            assign w_ps = 61'(r_hx2[2*gj]) * 61'(w_ts[gj]) + (61'd1 << 29);
            assign w_pc = 61'(r_hx2[2*gj]) * 61'(w_tc[gj]) + (61'd1 << 29);
            assign w_ms = 66'(r_va_s[gj]) * 66'(SIN_M[gj]);
            assign w_mc = 66'(r_va_c[gj]) * 66'(COS_M[gj]);
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_va_s[gj] <= 32'(w_ps[60:30]) + SIN_HALF[gj];
                    r_va_c[gj] <= 32'(w_pc[60:30]) + COS_HALF[gj];
                    r_tb_s[gj] <= ONE_Q30 - 31'(w_ms >> SIN_S[gj]);
                    r_tb_c[gj] <= ONE_Q30 - 31'(w_mc >> COS_S[gj]);
                end
            end
            assign w_ts[gj+1] = r_tb_s[gj];
            assign w_tc[gj+1] = r_tb_c[gj];
        end
    endgenerate

    assign w_sp = 61'(r_hx[2*NSTEP]) * 61'(w_ts[NSTEP]) + (61'd1 << 29);
    assign w_sr = 32'(w_sp[60:30]) + 32'd16384;
    assign w_cr = 32'(w_tc[NSTEP]) + 32'd16384;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_f_s    <= w_sr[30:15];
            r_f_c    <= w_cr[30:15];
            r_f_quad <= r_hq[2*NSTEP];
            r_f_swap <= r_hw[2*NSTEP];
        end
    end

    // undo octant reflection, then place in quadrant
    assign w_sv = r_f_swap ? $signed({1'b0, r_f_c}) : $signed({1'b0, r_f_s});
    assign w_cv = r_f_swap ? $signed({1'b0, r_f_s}) : $signed({1'b0, r_f_c});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            unique case (r_f_quad)
                2'd0: begin
                    o_sin <= w_sv;
                    o_cos <= w_cv;
                end
                2'd1: begin
                    o_sin <= w_cv;
                    o_cos <= -w_sv;
                end
                2'd2: begin
                    o_sin <= -w_sv;
                    o_cos <= -w_cv;
                end
                default: begin
                    o_sin <= -w_cv;
                    o_cos <= w_sv;
                end
            endcase
        end
    end

endmodule

FILE: rtl/core/etrs_back.sv
module etrs_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  etrs_pkg::t_work   i_head,
    input  etrs_pkg::t_q_stat i_qs,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_stall,
    output etrs_pkg::t_out    o_data
);
    import etrs_pkg::*;

    logic [BACK_LAT-1:0] r_vld;
    logic                w_en;
    t_side               r_side [SIDE_LEN];

    logic signed [16:0] w_sx, w_cx, w_sy, w_cy, w_sz, w_cz;

    // pair products
    logic signed [33:0] r_czcy, r_czsy, r_szcx, r_szsx, r_szcy;
    logic signed [33:0] r_szsy, r_czcx, r_czsx, r_cysx, r_cycx;
    logic signed [16:0] r_p_sx, r_p_cx, r_p_sy;

    logic signed [47:0] r_r    [9];
    logic [31:0]        r_rmag [9];
    logic [31:0]        r_smag [9];
    logic               r_neg3 [9];
    logic [63:0]        r_prod [9];
    logic               r_neg4 [9];
    logic [31:0]        r_qc   [9];
    logic               r_neg5 [9];
    logic [31:0]        r_out  [9];
    logic signed [DATA_W-1:0] r_tx, r_ty, r_tz;
    logic signed [DATA_W-1:0] w_sc [3];

    assign w_en    = !r_vld[BACK_LAT-1] || !i_stall;
    assign o_pop   = w_en && !i_qs.empty;
    assign o_valid = r_vld[BACK_LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else if (w_en) r_vld <= {r_vld[BACK_LAT-2:0], o_pop};
    end

    always_ff @(posedge i_clk) begin
        if (w_en) r_side[0] <= i_head.side;
    end

    genvar gk;
    generate
        for (gk = 1; gk < SIDE_LEN; gk++) begin : g_side
            always_ff @(posedge i_clk) begin
                if (w_en) r_side[gk] <= r_side[gk-1];
            end
        end
    endgenerate

    etrs_sincos u_sc_x (.i_clk(i_clk), .i_en(w_en), .i_ang(i_head.ang_x),
                        .o_sin(w_sx), .o_cos(w_cx));
    etrs_sincos u_sc_y (.i_clk(i_clk), .i_en(w_en), .i_ang(i_head.ang_y),
                        .o_sin(w_sy), .o_cos(w_cy));
    etrs_sincos u_sc_z (.i_clk(i_clk), .i_en(w_en), .i_ang(i_head.ang_z),
                        .o_sin(w_sz), .o_cos(w_cz));

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_czcy <= 34'(w_cz) * 34'(w_cy);
            r_czsy <= 34'(w_cz) * 34'(w_sy);
            r_szcx <= 34'(w_sz) * 34'(w_cx);
            r_szsx <= 34'(w_sz) * 34'(w_sx);
            r_szcy <= 34'(w_sz) * 34'(w_cy);
            r_szsy <= 34'(w_sz) * 34'(w_sy);
            r_czcx <= 34'(w_cz) * 34'(w_cx);
            r_czsx <= 34'(w_cz) * 34'(w_sx);
            r_cysx <= 34'(w_cy) * 34'(w_sx);
            r_cycx <= 34'(w_cy) * 34'(w_cx);
            r_p_sx <= w_sx;
            r_p_cx <= w_cx;
            r_p_sy <= w_sy;
        end
    end

    // rotation entries in Q45
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_r[0] <= 48'(r_czcy) <<< 15;
            r_r[1] <= 48'(r_czsy) * 48'(r_p_sx) - (48'(r_szcx) <<< 15);
            r_r[2] <= 48'(r_czsy) * 48'(r_p_cx) + (48'(r_szsx) <<< 15);
            r_r[3] <= 48'(r_szcy) <<< 15;
            r_r[4] <= 48'(r_szsy) * 48'(r_p_sx) + (48'(r_czcx) <<< 15);
            r_r[5] <= 48'(r_szsy) * 48'(r_p_cx) - (48'(r_czsx) <<< 15);
            r_r[6] <= -(48'(r_p_sy) <<< 30);
            r_r[7] <= 48'(r_cysx) <<< 15;
            r_r[8] <= 48'(r_cycx) <<< 15;
        end
    end

    assign w_sc[0] = r_side[16].scale_x;
    assign w_sc[1] = r_side[16].scale_y;
    assign w_sc[2] = r_side[16].scale_z;

    generate
        for (gk = 0; gk < 9; gk++) begin : g_ent
            logic [47:0] w_abs;
            logic [47:0] w_rnd;
            logic [31:0] w_su;
            logic        w_sneg;
            logic [63:0] w_qr;
            logic [33:0] w_q;
            logic [33:0] w_lim;
            assign w_abs  = r_r[gk][47] ? 48'(-r_r[gk]) : 48'(r_r[gk]);
            assign w_rnd  = w_abs + 48'd16384;
            assign w_sneg = w_sc[gk % 3][DATA_W-1];
            assign w_su   = w_sc[gk % 3];
            assign w_qr   = r_prod[gk] + (64'd1 << 29);
            assign w_q    = w_qr[63:30];
            assign w_lim  = r_neg4[gk] ? 34'h0_8000_0000 : 34'h0_7FFF_FFFF;
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_rmag[gk] <= w_rnd[46:15];
                    r_smag[gk] <= w_sneg ? (~w_su + 32'd1) : w_su;
                    r_neg3[gk] <= r_r[gk][47] ^ w_sneg;
                    r_prod[gk] <= 64'(r_rmag[gk]) * 64'(r_smag[gk]);
                    r_neg4[gk] <= r_neg3[gk];
                    r_qc[gk]   <= (w_q > w_lim) ? w_lim[31:0] : w_q[31:0];
                    r_neg5[gk] <= r_neg4[gk];
                    r_out[gk]  <= r_neg5[gk] ? (~r_qc[gk] + 32'd1) : r_qc[gk];
                end
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_tx <= r_side[SIDE_LEN-1].pos_x;
            r_ty <= r_side[SIDE_LEN-1].pos_y;
            r_tz <= r_side[SIDE_LEN-1].pos_z;
        end
    end

    always_comb begin
        o_data.m00 = r_out[0];
        o_data.m01 = r_out[1];
        o_data.m02 = r_out[2];
        o_data.m10 = r_out[3];
        o_data.m11 = r_out[4];
        o_data.m12 = r_out[5];
        o_data.m20 = r_out[6];
        o_data.m21 = r_out[7];
        o_data.m22 = r_out[8];
        o_data.tx  = r_tx;
        o_data.ty  = r_ty;
        o_data.tz  = r_tz;
    end

endmodule

FILE: tb/euler_trs_matrix_compose_tb.sv
module euler_trs_matrix_compose_tb;
    import etrs_pkg::*;

    localparam longint unsigned PI_Q30  = 64'd3373259426;
    localparam longint unsigned ONE_Q30U = 64'd1 << 30;
    localparam int              N_RANDOM = 1950;
    localparam int              DEG      = 64;   // one degree in angle units

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_stall;
    t_in  i_data;
    logic o_valid;
    logic i_stall;
    t_out o_data;

    euler_trs_matrix_compose u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_data (i_data),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_data (o_data)
    );

    // Directed row: an item plus, where obvious, its hand-written matrix.
    typedef struct {
        t_in  item;
        bit   has_mat;
        t_out mat;
    } t_row;

    t_out matrix_q[$];     // expected matrices, oldest first
    int   n_errors;
    int   n_sent;
    int   n_matched;
    bit   feed_done;
    bit   hold_req;        // asks the receiver for one long hold-off

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Q30 product rounded to nearest.
    function automatic longint unsigned q30_mul(longint unsigned a, longint unsigned b);
        return (a * b + (64'd1 << 29)) >> 30;
    endfunction

    // Sine and cosine in Q15 of an angle in degrees Q10.6.
    function automatic void trig_q15(input logic signed [ANG_W-1:0] ang,
                                     output longint s, output longint c);
        longint          r;
        longint          quad;
        longint          f;
        bit              refl;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned ts;
        longint unsigned tc;
        longint          s0;
        longint          c0;
        longint          tmp;
        longint unsigned sdiv [5];
        longint unsigned cdiv [5];
        sdiv = '{110, 72, 42, 20, 6};
        cdiv = '{90, 56, 30, 12, 2};
        r = longint'(ang) % 23040;
        if (r < 0) r += 23040;
        quad = r / 5760;
        f = r % 5760;
        refl = 1'b0;
        if (f > 2880) begin
            f = 5760 - f;
            refl = 1'b1;
        end
        x  = (longint'(f) * PI_Q30 + 64'd5760) / 64'd11520;
        x2 = q30_mul(x, x);
        ts = ONE_Q30U;
        tc = ONE_Q30U;
        for (int i = 0; i < 5; i++) begin
            ts = ONE_Q30U - (q30_mul(x2, ts) + sdiv[i] / 2) / sdiv[i];
            tc = ONE_Q30U - (q30_mul(x2, tc) + cdiv[i] / 2) / cdiv[i];
        end
        s0 = longint'((q30_mul(x, ts) + (64'd1 << 14)) >> 15);
        c0 = longint'((tc + (64'd1 << 14)) >> 15);
        if (refl) begin
            tmp = s0;
            s0 = c0;
            c0 = tmp;
        end
        case (quad)
            0: begin s = s0;  c = c0;  end
            1: begin s = c0;  c = -s0; end
            2: begin s = -s0; c = -c0; end
            default: begin s = -c0; c = s0; end
        endcase
    endfunction

    // Q45 rotation entry times a Q16.16 scale, rounded half away, saturated.
    function automatic logic [DATA_W-1:0] scale_entry(longint r45, logic [DATA_W-1:0] sc);
        bit              rneg;
        bit              sneg;
        bit              neg;
        longint unsigned rmag;
        longint unsigned smag;
        longint unsigned q;
        longint unsigned lim;
        logic [DATA_W-1:0] neg_sc;
        rneg = r45 < 0;
        rmag = rneg ? longint'(-r45) : longint'(r45);
        rmag = (rmag + (64'd1 << 14)) >> 15;
        sneg = sc[DATA_W-1];
        neg_sc = -sc;
        smag = sneg ? {32'd0, neg_sc} : {32'd0, sc};
        neg = rneg != sneg;
        q = (rmag * smag + (64'd1 << 29)) >> 30;
        lim = neg ? (64'd1 << (DATA_W-1)) : ((64'd1 << (DATA_W-1)) - 1);
        if (q > lim) q = lim;
        return neg ? DATA_W'(-q) : DATA_W'(q);
    endfunction

    // Compose T*Rz*Ry*Rx*S for one item.
    function automatic t_out compose_trs(t_in d);
        longint sx, cx, sy, cy, sz, cz;
        longint k;
        longint rot [9];
        logic [DATA_W-1:0] sc [3];
        t_out o;
        trig_q15(d.angle_x, sx, cx);
        trig_q15(d.angle_y, sy, cy);
        trig_q15(d.angle_z, sz, cz);
        k = 32768;
        rot[0] = cz * cy * k;
        rot[1] = cz * sy * sx - sz * cx * k;
        rot[2] = cz * sy * cx + sz * sx * k;
        rot[3] = sz * cy * k;
        rot[4] = sz * sy * sx + cz * cx * k;
        rot[5] = sz * sy * cx - cz * sx * k;
        rot[6] = -sy * k * k;
        rot[7] = cy * sx * k;
        rot[8] = cy * cx * k;
        sc[0] = d.scale_x;
        sc[1] = d.scale_y;
        sc[2] = d.scale_z;
        o.m00 = scale_entry(rot[0], sc[0]);
        o.m01 = scale_entry(rot[1], sc[1]);
        o.m02 = scale_entry(rot[2], sc[2]);
        o.m10 = scale_entry(rot[3], sc[0]);
        o.m11 = scale_entry(rot[4], sc[1]);
        o.m12 = scale_entry(rot[5], sc[2]);
        o.m20 = scale_entry(rot[6], sc[0]);
        o.m21 = scale_entry(rot[7], sc[1]);
        o.m22 = scale_entry(rot[8], sc[2]);
        o.tx = d.pos_x;
        o.ty = d.pos_y;
        o.tz = d.pos_z;
        return o;
    endfunction

    function automatic t_in make_item(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                                      logic [15:0] ax, logic [15:0] ay, logic [15:0] az,
                                      logic [31:0] kx, logic [31:0] ky, logic [31:0] kz);
        t_in d;
        d.pos_x = px;   d.pos_y = py;   d.pos_z = pz;
        d.angle_x = ax; d.angle_y = ay; d.angle_z = az;
        d.scale_x = kx; d.scale_y = ky; d.scale_z = kz;
        return d;
    endfunction

    // Diagonal matrix with the position in the last column.
    function automatic t_out diag_mat(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                                      t_in d);
        t_out o;
        o = '0;
        o.m00 = a; o.m11 = b; o.m22 = c;
        o.tx = d.pos_x; o.ty = d.pos_y; o.tz = d.pos_z;
        return o;
    endfunction

    // Random item; mostly realistic content, with extremes and exact angles mixed in.
    function automatic t_in rand_item();
        t_in d;
        logic [31:0] sc [3];
        logic [15:0] an [3];
        d.pos_x = $urandom;
        d.pos_y = $urandom;
        d.pos_z = $urandom;
        for (int i = 0; i < 3; i++) begin
            case ($urandom_range(0, 9))
                0, 1:    an[i] = 16'(($urandom_range(0, 22) - 11) * 45 * DEG);
                2:       an[i] = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
                3:       an[i] = 16'(2880 + $urandom_range(0, 2) - 1);
                default: an[i] = 16'($urandom);
            endcase
            case ($urandom_range(0, 9))
                0:       sc[i] = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
                1, 2:    sc[i] = $urandom;
                3:       sc[i] = -(32'h0001_0000 + $urandom_range(0, 4095));
                default: sc[i] = 32'h0001_0000 + $urandom_range(0, 32'h3_ffff) - 32'h2_0000;
            endcase
        end
        d.angle_x = an[0]; d.angle_y = an[1]; d.angle_z = an[2];
        d.scale_x = sc[0]; d.scale_y = sc[1]; d.scale_z = sc[2];
        return d;
    endfunction

    // Offer one item after a drawn gap, or at once in a burst; return once it is taken.
    task automatic send_item(t_in d, bit has_mat, t_out mat, bit burst);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_data  = d;
        forever begin
            @(posedge i_clk);
            if (!o_stall) break;
        end
        matrix_q.push_back(has_mat ? mat : compose_trs(d));
        n_sent++;
        @(negedge i_clk);
    endtask

    // Stimulus: directed table first, then random items.
    initial begin
        t_row  rows [$];
        t_row  row;
        t_in   d;
        bit    burst;
        int    hold_at;
        i_valid   = 1'b0;
        i_data    = '0;
        i_rst_n   = 1'b0;
        n_sent    = 0;
        feed_done = 1'b0;
        hold_req  = 1'b0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Identity rotation with unit, largest and most negative scales.
        d = make_item(32'h0001_0000, 32'hffff_0000, 32'h0, 16'h0, 16'h0, 16'h0,
                      32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
        rows.push_back('{d, 1'b1, diag_mat(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, d)});
        d = make_item(32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 16'h0, 16'h0, 16'h0,
                      32'h7fff_ffff, 32'h8000_0000, 32'h0);
        rows.push_back('{d, 1'b1, diag_mat(32'h7fff_ffff, 32'h8000_0000, 32'h0, d)});
        d = make_item(32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0,
                      32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff);
        rows.push_back('{d, 1'b1, diag_mat(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, d)});
        // A full turn wraps back to zero.
        d = make_item(32'h1234_5678, 32'h0, 32'h0, 16'(360 * DEG), 16'(-360 * DEG), 16'h0,
                      32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
        rows.push_back('{d, 1'b1, diag_mat(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, d)});
        // Ninety degrees about x: y goes to z.
        d = make_item(32'h0, 32'h0, 32'h0, 16'(90 * DEG), 16'h0, 16'h0,
                      32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
        row = '{d, 1'b1, diag_mat(32'h0001_0000, 32'h0, 32'h0, d)};
        row.mat.m12 = 32'hffff_0000;
        row.mat.m21 = 32'h0001_0000;
        rows.push_back(row);
        // Angle extremes, octant and quadrant edges, and saturation candidates.
        rows.push_back('{make_item(0, 0, 0, 16'h7fff, 16'h8000, 16'h7fff,
                         32'h0001_0000, 32'h0001_0000, 32'h0001_0000), 1'b0, '0});
        rows.push_back('{make_item(0, 0, 0, 16'h8000, 16'h7fff, 16'h8000,
                         32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff), 1'b0, '0});
        rows.push_back('{make_item(0, 0, 0, 16'h8000, 16'h8000, 16'h8000,
                         32'h8000_0000, 32'h8000_0000, 32'h8000_0000), 1'b0, '0});
        rows.push_back('{make_item(0, 0, 0, 16'd2880, 16'd2879, 16'd2881,
                         32'h0001_0000, 32'h0001_0000, 32'h0001_0000), 1'b0, '0});
        rows.push_back('{make_item(0, 0, 0, 16'(45 * DEG), 16'(45 * DEG), 16'(45 * DEG),
                         32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff), 1'b0, '0});
        rows.push_back('{make_item(0, 0, 0, 16'(-45 * DEG), 16'(135 * DEG), 16'(-135 * DEG),
                         32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000), 1'b0, '0});
        rows.push_back('{make_item(0, 0, 0, 16'(180 * DEG), 16'(270 * DEG), 16'(-90 * DEG),
                         32'h0002_8000, 32'hfffe_0000, 32'h0000_0001), 1'b0, '0});
        rows.push_back('{make_item(0, 0, 0, 16'(30 * DEG), 16'(60 * DEG), 16'(450 * DEG),
                         32'h0001_0000, 32'h0001_0000, 32'h0001_0000), 1'b0, '0});
        rows.push_back('{make_item(32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                         16'hffff, 16'h0001, 16'haaaa, 32'h5555_5555, 32'haaaa_aaaa,
                         32'hffff_ffff), 1'b0, '0});
        rows.push_back('{make_item(32'h5555_5555, 32'haaaa_aaaa, 32'h0000_0001,
                         16'h5555, 16'h2aaa, 16'hd555, 32'h0000_0001, 32'hffff_ffff,
                         32'h8000_0001), 1'b0, '0});

        foreach (rows[i]) send_item(rows[i].item, rows[i].has_mat, rows[i].mat, 1'b0);

        // Random part: stretches of a hundred items, each drawn as gapped or back to back.
        burst = 1'b0;
        hold_at = $urandom_range(300, 900);
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i % 100 == 0) burst = $urandom_range(0, 2) == 0;
            if (i == hold_at) hold_req = 1'b1;
            // keep offering back to back while the receiver holds off
            send_item(rand_item(), 1'b0, '0, burst || hold_req);
        end
        i_valid = 1'b0;
        feed_done = 1'b1;
    end

    // Receiver: random stall before each result, plus one long hold-off.
    initial begin
        int wait_cycles;
        i_stall = 1'b1;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                // hold long enough to fill the block and back up the input
                i_stall = 1'b1;
                repeat (200) @(negedge i_clk);
                hold_req = 1'b0;
            end
            wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
            i_stall = wait_cycles != 0;
            if (wait_cycles != 0) begin
                repeat (wait_cycles) @(negedge i_clk);
                i_stall = 1'b0;
            end
            // advance once a result is taken
            forever begin
                @(posedge i_clk);
                if (o_valid) break;
            end
        end
    end

    // Compare each taken result with the oldest expected matrix.
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (matrix_q.size() == 0) begin
                $display("%0t: unexpected result %h", $time, o_data);
                n_errors++;
            end else begin
                want = matrix_q.pop_front();
                if (want !== o_data) begin
                    $display("%0t: matrix mismatch expected %h actual %h", $time, want, o_data);
                    n_errors++;
                end else begin
                    n_matched++;
                end
            end
        end
    end

    // Drain, check for leftovers, report.
    initial begin
        n_errors  = 0;
        n_matched = 0;
        wait (feed_done);
        wait (matrix_q.size() == 0);
        repeat (40) @(posedge i_clk);
        if (matrix_q.size() != 0) begin
            $display("%0t: %0d expected matrices never arrived", $time, matrix_q.size());
            n_errors++;
        end
        $display("Covered %0d items: directed extremes, angle wraps and octant edges,", n_sent);
        $display("random angles and scales with gaps, bursts and a long output hold-off.");
        if (n_errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Guard against a hang.
    initial begin
        #5000000;
        $display("%0t: timeout with %0d matrices outstanding", $time, matrix_q.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule
